### hw/rtl/skht_pkg.sv
// ----------------------------------------------------------------------------
// skht_pkg: shared types and constants of the string key hash table
// Mode and status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package skht_pkg;

  localparam int CAPACITY_DEF      = 256;
  localparam int MAX_KEY_BYTES_DEF = 16;

  localparam logic [31:0] FNV_OFFSET = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME  = 32'h01000193;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_FINISH = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] STAT_FOUND    = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_ABSENT   = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_TOO_LONG = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MOD,
    ST_RD_META,
    ST_CHK_META,
    ST_RD_BYTE,
    ST_CHK_BYTE,
    ST_CPY_RD,
    ST_CPY_WR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic       append;
    logic       clr_start;
    logic       clr_step;
    logic       finish;
    logic       mod_step;
    logic       rd_meta;
    logic       probe_adv;
    logic       byte_rst;
    logic       rd_byte;
    logic       byte_adv;
    logic       ins_meta;
    logic       cpy_wr;
    logic       res_set;
    logic [2:0] res_code;
    logic       res_slot;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic overflow;
    logic mod_last;
    logic clr_last;
    logic meta_used;
    logic meta_match;
    logic len_zero;
    logic probe_last;
    logic byte_eq;
    logic byte_last;
    logic add;
    logic full;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/skht_if.sv
// ----------------------------------------------------------------------------
// skht_in_if / skht_out_if: key and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface skht_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] key_byte;
  logic       add;

  modport source (output valid, mode, key_byte, add, input ready);
  modport sink   (input valid, mode, key_byte, add, output ready);
endinterface

interface skht_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  slot;
  logic [31:0] key_hash;

  modport source (output valid, status, slot, key_hash, input ready);
  modport sink   (input valid, status, slot, key_hash, output ready);
endinterface

### hw/rtl/skht_ctrl.sv
// ----------------------------------------------------------------------------
// skht_ctrl: sequencer of the hash table
// Steps through clear sweep, hash reduction, probing, compare and copy.
// ----------------------------------------------------------------------------
module skht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        mode,
  output logic              in_ready,
  input  skht_pkg::status_t st,
  output skht_pkg::cmd_t    cmd
);
  import skht_pkg::*;

  state_t state, state_next;
  logic   acc;

  assign in_ready = (state == ST_IDLE);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (mode)
            MODE_FINISH: state_next = st.overflow ? ST_RESULT : ST_MOD;
            MODE_CLEAR:  state_next = ST_CLEAR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:   if (st.clr_last) state_next = ST_IDLE;
      ST_MOD:     if (st.mod_last) state_next = ST_RD_META;
      ST_RD_META: state_next = ST_CHK_META;
      ST_CHK_META: begin
        if (!st.meta_used) begin
          if (!st.add || st.full || st.len_zero) state_next = ST_RESULT;
          else                                   state_next = ST_CPY_RD;
        end else if (st.meta_match) begin
          state_next = st.len_zero ? ST_RESULT : ST_RD_BYTE;
        end else begin
          state_next = st.probe_last ? ST_RESULT : ST_RD_META;
        end
      end
      ST_RD_BYTE: state_next = ST_CHK_BYTE;
      ST_CHK_BYTE: begin
        if (!st.byte_eq) state_next = st.probe_last ? ST_RESULT : ST_RD_META;
        else             state_next = st.byte_last ? ST_RESULT : ST_RD_BYTE;
      end
      ST_CPY_RD: state_next = ST_CPY_WR;
      ST_CPY_WR: state_next = st.byte_last ? ST_RESULT : ST_CPY_RD;
      ST_RESULT: if (st.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (mode)
            MODE_APPEND: cmd.append = 1'b1;
            MODE_FINISH: begin
              cmd.finish = 1'b1;
              if (st.overflow) begin
                cmd.res_set  = 1'b1;
                cmd.res_code = STAT_TOO_LONG;
              end
            end
            MODE_CLEAR: cmd.clr_start = 1'b1;
            default:    cmd = '0;
          endcase
        end
      end
      ST_CLEAR:   cmd.clr_step = 1'b1;
      ST_MOD:     cmd.mod_step = 1'b1;
      ST_RD_META: cmd.rd_meta  = 1'b1;
      ST_CHK_META: begin
        cmd.byte_rst = 1'b1;
        if (!st.meta_used) begin
          cmd.res_set = 1'b1;
          if (!st.add) begin
            cmd.res_code = STAT_ABSENT;
          end else if (st.full) begin
            cmd.res_code = STAT_FULL;
          end else begin
            cmd.ins_meta = 1'b1;
            cmd.res_code = STAT_INSERTED;
            cmd.res_slot = 1'b1;
          end
        end else if (st.meta_match) begin
          if (st.len_zero) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = STAT_FOUND;
            cmd.res_slot = 1'b1;
          end
        end else if (st.probe_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = st.add ? STAT_FULL : STAT_ABSENT;
        end else begin
          cmd.probe_adv = 1'b1;
        end
      end
      ST_RD_BYTE: cmd.rd_byte = 1'b1;
      ST_CHK_BYTE: begin
        if (!st.byte_eq) begin
          if (st.probe_last) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = st.add ? STAT_FULL : STAT_ABSENT;
          end else begin
            cmd.probe_adv = 1'b1;
          end
        end else if (st.byte_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_FOUND;
          cmd.res_slot = 1'b1;
        end else begin
          cmd.byte_adv = 1'b1;
        end
      end
      ST_CPY_RD: cmd.rd_byte = 1'b1;
      ST_CPY_WR: begin
        cmd.cpy_wr   = 1'b1;
        cmd.byte_adv = !st.byte_last;
      end
      ST_RESULT: cmd.out_load = st.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

### hw/rtl/skht_dp.sv
// ----------------------------------------------------------------------------
// skht_dp: datapath of the hash table
// Hash and key buffer, reciprocal reduction, slot memories, result register.
// ----------------------------------------------------------------------------
module skht_dp #(
  parameter int CAPACITY      = skht_pkg::CAPACITY_DEF,
  parameter int MAX_KEY_BYTES = skht_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  skht_pkg::cmd_t    cmd,
  output skht_pkg::status_t st,
  input  logic [7:0]        key_byte,
  input  logic              add,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [7:0]        slot,
  output logic [31:0]       key_hash
);
  import skht_pkg::*;

  localparam int SW      = $clog2(CAPACITY);
  localparam int LW      = $clog2(MAX_KEY_BYTES + 1);
  localparam int IW      = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int OW      = $clog2(CAPACITY + 1);
  localparam int MW      = 1 + 32 + LW;
  localparam int OCC_MAX = (CAPACITY + 1) / 2;

  // ceil(2^(32+SW) / CAPACITY): exact quotient for every 32-bit hash
  localparam logic [32:0] RECIP =
    33'(((65'd1 << (32 + SW)) + 65'(CAPACITY - 1)) / 65'(CAPACITY));

  localparam logic [SW-1:0] S_LAST  = SW'(CAPACITY - 1);
  localparam logic [OW:0]   CAP_OCC = (OW + 1)'(CAPACITY);

  logic [31:0]     running_hash;
  logic [LW-1:0]   key_len;
  logic            overflow;
  logic            add_q;
  logic [SW-1:0]   s;
  logic [SW-1:0]   n;
  logic            mod_hi;
  logic [31:0]     quo;
  logic [IW-1:0]   idx;
  logic [OW-1:0]   occ;
  logic [2:0]      res_code;
  logic            res_slot;
  logic [MW-1:0]   meta_q;
  logic [7:0]      kb_q;
  logic [7:0]      sb_q;

  logic [MW-1:0]   meta  [CAPACITY];
  logic [7:0]      kbuf  [MAX_KEY_BYTES];
  logic [7:0]      sbytes[CAPACITY << IW];

  logic [64:0]     recip_prod;
  logic [31:0]     rem_w;
  logic [SW-1:0]   s_inc;
  logic            len_full;
  logic            meta_we;
  logic [MW-1:0]   meta_wd;

  // Hash mod capacity: quotient by reciprocal multiply, then subtract
  assign recip_prod = 65'(running_hash) * 65'(RECIP);
  assign rem_w      = running_hash - quo * 32'(CAPACITY);
  assign s_inc    = (s == S_LAST) ? '0 : s + SW'(1);
  assign len_full = (key_len == LW'(MAX_KEY_BYTES));
  assign meta_we  = cmd.clr_step || cmd.ins_meta;
  assign meta_wd  = cmd.ins_meta ? {1'b1, running_hash, key_len} : '0;

  assign st.overflow   = overflow;
  assign st.mod_last   = mod_hi;
  assign st.clr_last   = (s == S_LAST);
  assign st.meta_used  = meta_q[MW-1];
  assign st.meta_match = (meta_q[MW-2 -: 32] == running_hash) &&
                         (meta_q[LW-1:0] == key_len);
  assign st.len_zero   = (key_len == '0);
  assign st.probe_last = (n == S_LAST);
  assign st.byte_eq    = (kb_q == sb_q);
  assign st.byte_last  = (LW'(idx) == key_len - LW'(1));
  assign st.add        = add_q;
  assign st.full       = ({occ, 1'b0} >= CAP_OCC);
  assign st.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_OFFSET;
      key_len      <= '0;
      overflow     <= 1'b0;
      s            <= '0;
      occ          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.append) begin
        running_hash <= (running_hash ^ {24'd0, key_byte}) * FNV_PRIME;
        if (len_full) overflow <= 1'b1;
        else          key_len  <= key_len + LW'(1);
      end
      if (cmd.clr_start || cmd.finish) begin
        s <= '0;
      end else if (cmd.clr_step || cmd.probe_adv) begin
        s <= s_inc;
      end else if (cmd.mod_step && mod_hi) begin
        s <= SW'(rem_w);
      end
      if (cmd.clr_start)     occ <= '0;
      else if (cmd.ins_meta) occ <= occ + OW'(1);
      if (cmd.out_load) begin
        out_valid    <= 1'b1;
        running_hash <= FNV_OFFSET;
        key_len      <= '0;
        overflow     <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      add_q  <= add;
      mod_hi <= 1'b0;
      n      <= '0;
    end
    if (cmd.mod_step) mod_hi <= 1'b1;
    if (cmd.mod_step && !mod_hi) quo <= 32'(recip_prod >> (32 + SW));
    if (cmd.probe_adv) n    <= n + SW'(1);
    if (cmd.byte_rst)      idx <= '0;
    else if (cmd.byte_adv) idx <= idx + IW'(1);
    if (cmd.res_set) begin
      res_code <= cmd.res_code;
      res_slot <= cmd.res_slot;
    end
    if (cmd.out_load) begin
      status   <= res_code;
      slot     <= res_slot ? 8'(s) : 8'd0;
      key_hash <= running_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we)     meta[s] <= meta_wd;
    if (cmd.rd_meta) meta_q  <= meta[s];
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !len_full) kbuf[key_len[IW-1:0]] <= key_byte;
    if (cmd.rd_byte)             kb_q <= kbuf[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.cpy_wr)  sbytes[{s, idx}] <= kb_q;
    if (cmd.rd_byte) sb_q             <= sbytes[{s, idx}];
  end

  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_meta |-> !st.full)
    else $error("insert while table full");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(OCC_MAX))
    else $error("occupancy beyond half capacity");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    s <= S_LAST)
    else $error("slot index out of range");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over a pending beat");

endmodule

### hw/rtl/string_key_hash_table_lookup_insert.sv
// ----------------------------------------------------------------------------
// string_key_hash_table_lookup_insert: FNV-1a keyed table, linear probing
// Builds a key one byte per beat, then looks it up or inserts it.
// ----------------------------------------------------------------------------
//
//  channel     dir  payload                    beat means
//  key_in      in   mode, key_byte, add        one key byte, finish or clear
//  result_out  out  status, slot, key_hash     one answer per finish
//
// Sequence: an append is taken in the idle state; a clear sweeps the slot
// words, one per cycle. A finish reduces the hash mod CAPACITY by reciprocal
// multiply (quotient, then remainder), reads each probed slot word, compares
// key bytes on a match, copies them on insert, and ends in its result state.
// Reset: sweeps all CAPACITY slot words clear before key_in goes ready.
// Stalls: the result sits in an output register; the block holds in its
// result state only when a previous beat is still not taken.
// ----------------------------------------------------------------------------
module string_key_hash_table_lookup_insert #(
  parameter int CAPACITY      = skht_pkg::CAPACITY_DEF,
  parameter int MAX_KEY_BYTES = skht_pkg::MAX_KEY_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  skht_in_if.sink    key_in,
  skht_out_if.source result_out
);
  import skht_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequence control
  skht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (key_in.valid),
    .mode     (key_in.mode),
    .in_ready (key_in.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // hash, buffers, slot memories and result register
  skht_dp #(
    .CAPACITY      (CAPACITY),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .key_byte  (key_in.key_byte),
    .add       (key_in.add),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .status    (result_out.status),
    .slot      (result_out.slot),
    .key_hash  (result_out.key_hash)
  );

endmodule

### test/skht_checker.sv
// ----------------------------------------------------------------------------
// skht_checker: table lookup predictor and result scoreboard
// Watches the key and result channels, folds every accepted key beat into a
// private model of the hash table and compares each result beat in order.
// ----------------------------------------------------------------------------
module skht_checker #(
  parameter int SLOTS     = skht_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = skht_pkg::MAX_KEY_BYTES_DEF
) (
  input logic clk,
  input logic rst,
  skht_in_if  key_in,
  skht_out_if result_out,
  output int  errors,
  output int  pending
);
  import skht_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [31:0] key_hash;
  } answer_t;

  answer_t     answers_due[$];

  logic [31:0] fnv_acc;
  logic [7:0]  key_buf [KEY_BYTES];
  int          key_len;
  bit          key_ovf;
  bit          slot_busy [SLOTS];
  logic [31:0] slot_fnv [SLOTS];
  int          slot_len [SLOTS];
  logic [7:0]  slot_key [SLOTS][KEY_BYTES];
  int          fill;

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
    errors++;
  endtask

  function automatic bit slot_holds_key(int s, logic [31:0] h);
    if (slot_fnv[s] != h || slot_len[s] != key_len) return 0;
    for (int i = 0; i < key_len; i++)
      if (slot_key[s][i] != key_buf[i]) return 0;
    return 1;
  endfunction

  task automatic fold_key_beat(logic [1:0] m, logic [7:0] b, logic a);
    answer_t ans;
    int      s;
    bit      hit;
    bit      hole;
    case (m)
      MODE_APPEND: begin
        fnv_acc = (fnv_acc ^ {24'd0, b}) * FNV_PRIME;
        if (key_len < KEY_BYTES) begin
          key_buf[key_len] = b;
          key_len++;
        end else begin
          key_ovf = 1;
        end
      end
      MODE_CLEAR: begin
        foreach (slot_busy[i]) slot_busy[i] = 0;
        fill = 0;
      end
      MODE_FINISH: begin
        ans.key_hash = fnv_acc;
        ans.slot     = '0;
        if (key_ovf) begin
          ans.status = STAT_TOO_LONG;
        end else begin
          s    = fnv_acc % SLOTS;
          hit  = 0;
          hole = 0;
          for (int n = 0; n < SLOTS; n++) begin
            if (!slot_busy[s]) begin
              hole = 1;
              break;
            end
            if (slot_holds_key(s, fnv_acc)) begin
              hit = 1;
              break;
            end
            s = (s + 1) % SLOTS;
          end
          if (hit) begin
            ans.status = STAT_FOUND;
            ans.slot   = s[7:0];
          end else if (!a) begin
            ans.status = STAT_ABSENT;
          end else if (fill * 2 >= SLOTS || !hole) begin
            ans.status = STAT_FULL;
          end else begin
            slot_busy[s] = 1;
            slot_fnv[s]  = fnv_acc;
            slot_len[s]  = key_len;
            for (int i = 0; i < key_len; i++) slot_key[s][i] = key_buf[i];
            fill++;
            ans.status = STAT_INSERTED;
            ans.slot   = s[7:0];
          end
        end
        answers_due.push_back(ans);
        fnv_acc = FNV_OFFSET;
        key_len = 0;
        key_ovf = 0;
      end
      default: ;
    endcase
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    fnv_acc = FNV_OFFSET;
    key_len = 0;
    key_ovf = 0;
    fill    = 0;
    foreach (slot_busy[i]) slot_busy[i] = 0;
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (result_out.valid && result_out.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, result_out.key_hash);
        end else begin
          want = answers_due.pop_front();
          if (result_out.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(result_out.status));
          if (result_out.slot !== want.slot)
            report_mismatch("slot", 32'(want.slot), 32'(result_out.slot));
          if (result_out.key_hash !== want.key_hash)
            report_mismatch("key_hash", want.key_hash, result_out.key_hash);
        end
      end
      if (key_in.valid && key_in.ready)
        fold_key_beat(key_in.mode, key_in.key_byte, key_in.add);
      pending = answers_due.size();
    end
  end

endmodule

### test/string_key_hash_table_lookup_insert_tb.sv
// ----------------------------------------------------------------------------
// string_key_hash_table_lookup_insert_tb: stimulus and verdict
// Builds keys byte by byte, finishes them with and without insertion, fills
// the table to its refusal point, clears it, and runs the handshakes under
// three idle mixes plus a long result stall. Checking lives in skht_checker.
// ----------------------------------------------------------------------------
module string_key_hash_table_lookup_insert_tb;
  import skht_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;
  int   beats_sent;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   rx_hold_len;

  // a few keys are kept around so that lookups hit stored entries often
  logic [7:0] key_pool [8][$];

  skht_in_if  key_in ();
  skht_out_if result_out ();

  string_key_hash_table_lookup_insert uut (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in),
    .result_out (result_out)
  );

  skht_checker chk (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in),
    .result_out (result_out),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("string_key_hash_table_lookup_insert_tb NOT OK");
      $finish;
    end
  end

  // Result side: drop ready for a requested stretch, else at the idle rate.
  initial begin
    result_out.ready = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        result_out.ready <= 0;
        rx_hold_len--;
      end else begin
        result_out.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one beat; idle first at the sender rate. Valid is left high after
  // acceptance so the next beat can follow without a gap.
  task automatic send_beat(logic [1:0] m, logic [7:0] b, logic a);
    while ($urandom_range(99) < tx_idle_pct) begin
      key_in.valid <= 0;
      @(negedge clk);
    end
    key_in.valid    <= 1;
    key_in.mode     <= m;
    key_in.key_byte <= b;
    key_in.add      <= a;
    do @(posedge clk); while (!key_in.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_key(logic [7:0] bytes[$], logic a);
    foreach (bytes[i]) send_beat(MODE_APPEND, bytes[i], 1'b0);
    send_beat(MODE_FINISH, 8'($urandom), a);
  endtask

  // Random key: mostly short, sometimes pooled for repeats, sometimes too long.
  task automatic send_random_key();
    logic [7:0] bytes[$];
    int         n;
    int         pick;
    pick = $urandom_range(7);
    if ($urandom_range(1)) begin
      bytes = key_pool[pick];
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 16) : $urandom_range(4);
      repeat (n) bytes.push_back(8'($urandom));
      if (n <= 16) key_pool[pick] = bytes;
    end
    // mid-key clear or unused mode: neither may disturb the partial key
    if (bytes.size() > 1 && $urandom_range(30) == 0) begin
      send_beat(MODE_APPEND, bytes[0], 1'b0);
      send_beat(($urandom_range(1)) ? MODE_CLEAR : MODE_UNUSED, 8'($urandom),
                1'($urandom));
      bytes.delete(0);
    end
    send_key(bytes, $urandom_range(99) < 70);
  endtask

  initial begin
    logic [7:0] k[$];
    cycles      = 0;
    beats_sent  = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_len = 0;
    foreach (key_pool[i]) key_pool[i] = {};
    rst              = 1;
    key_in.valid     = 0;
    key_in.mode      = MODE_APPEND;
    key_in.key_byte  = '0;
    key_in.add       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty key insert and hit, byte extremes, unused mode,
    // clear in the middle of a key, lookups after the clear.
    k = {};
    send_key(k, 1'b1);
    send_key(k, 1'b0);
    k = {8'h00};
    send_key(k, 1'b1);
    k = {8'hff};
    send_key(k, 1'b0);
    send_beat(MODE_UNUSED, 8'hff, 1'b1);
    send_beat(MODE_APPEND, 8'h55, 1'b0);
    send_beat(MODE_CLEAR, 8'haa, 1'b1);
    send_beat(MODE_FINISH, 8'h00, 1'b1);
    k = {8'h00};
    send_key(k, 1'b0);
    k = {};
    send_key(k, 1'b0);

    // Phase 0: sender idles lightly, receiver heavily. Fill the table with
    // distinct one-byte keys past the half-full refusal point, then clear.
    tx_idle_pct = 22;
    rx_idle_pct = 77;
    for (int i = 0; i < 140; i++) begin
      k = {8'(i) ^ 8'h5a};
      send_key(k, 1'b1);
    end
    send_beat(MODE_CLEAR, 8'($urandom), 1'($urandom));
    while (beats_sent < 350) send_random_key();

    // Phase 1: roles swapped; stall results long enough to back up the input.
    tx_idle_pct = 77;
    rx_idle_pct = 22;
    rx_hold_len = 400;
    tx_idle_pct = 0;
    repeat (12) send_random_key();
    tx_idle_pct = 77;
    // hold the sender until every answer is in
    key_in.valid <= 0;
    wait (pending == 0);
    @(negedge clk);
    while (beats_sent < 480) send_random_key();

    // Phase 2: no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (beats_sent < 620) send_random_key();
    key_in.valid <= 0;

    // drain, then allow a clear or long probe to settle
    wait (pending == 0);
    repeat (600) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("string_key_hash_table_lookup_insert_tb OK");
    end else begin
      $display("string_key_hash_table_lookup_insert_tb NOT OK");
    end
    $finish;
  end

endmodule
